>>> hw/rtl/wis_pkg.sv
// ============================================================================
// wis_pkg
// Shared types, codes and defaults for the weighted item selector.
// ============================================================================
package wis_pkg;

    // Fixed port field widths
    localparam int FUNC_W   = 2;
    localparam int RANK_IW  = 3;
    localparam int ID_W     = 8;
    localparam int WEIGHT_IW = 16;
    localparam int FRAC_IW  = 16;
    localparam int STATUS_W = 3;
    localparam int NUM_IDS  = 2 ** ID_W;

    // Parameter defaults
    localparam int RANKS_DEF            = 8;
    localparam int ENTRIES_PER_RANK_DEF = 16;
    localparam int WEIGHT_BITS_DEF      = 16;
    localparam int RANDOM_BITS_DEF      = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_ROLL = 2'd1,
        FUNC_EXCL = 2'd2,
        FUNC_CLR  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BAD_RANK = 3'd1,
        STAT_DUP      = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NONE     = 3'd4,
        STAT_UNKNOWN  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        WALK_DUP  = 2'd0,
        WALK_SUM  = 2'd1,
        WALK_PICK = 2'd2
    } walk_mode_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;      // latch request fields
        logic       prep;      // fetch rank count, clear walk and sums
        logic       walk_en;   // step the entry walk
        walk_mode_t mode;      // what the walk does with each entry
        logic       mul_init;  // start scale multiply, rewind walk
        logic       mul_step;  // one multiplier bit
        logic       write;     // append entry to rank
        logic       excl;      // set mask bit if id present
        logic       clr;       // clear exclusion mask
        logic       res_en;    // post a result beat
        status_t    res_code;
        logic       res_pick;  // result carries the picked id
    } wis_cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t func;
        logic  rank_ok;
        logic  present;
        logic  full;
        logic  hit;
        logic  walk_done;
        logic  total_zero;
        logic  mul_done;
    } wis_stat_t;

endpackage

>>> hw/rtl/wis_ctrl.sv
// ============================================================================
// wis_ctrl
// Request sequencer: decode, entry walks, scale multiply, result post.
// ============================================================================
module wis_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wis_pkg::wis_stat_t stat,
    output wis_pkg::wis_cmd_t  cmd
);
    import wis_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_SUM    = 6'b001000,
        S_MUL    = 6'b010000,
        S_PICK   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.mode   = WALK_DUP;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.prep = 1'b1;
                case (stat.func)
                    FUNC_ADD:
                    begin
                        if (stat.rank_ok)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            cmd.res_en   = 1'b1;
                            cmd.res_code = STAT_BAD_RANK;
                            state_next   = S_IDLE;
                        end
                    end
                    FUNC_ROLL:
                    begin
                        if (stat.rank_ok)
                        begin
                            state_next = S_SUM;
                        end
                        else
                        begin
                            cmd.res_en   = 1'b1;
                            cmd.res_code = STAT_BAD_RANK;
                            state_next   = S_IDLE;
                        end
                    end
                    FUNC_EXCL:
                    begin
                        cmd.excl     = 1'b1;
                        cmd.res_en   = 1'b1;
                        cmd.res_code = stat.present ? STAT_OK : STAT_UNKNOWN;
                        state_next   = S_IDLE;
                    end
                    default:
                    begin
                        cmd.clr      = 1'b1;
                        cmd.res_en   = 1'b1;
                        cmd.res_code = STAT_OK;
                        state_next   = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.walk_en = 1'b1;
                cmd.mode    = WALK_DUP;
                if (stat.hit)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_code = STAT_DUP;
                    state_next   = S_IDLE;
                end
                else if (stat.walk_done)
                begin
                    cmd.res_en = 1'b1;
                    state_next = S_IDLE;
                    if (stat.full)
                    begin
                        cmd.res_code = STAT_FULL;
                    end
                    else
                    begin
                        cmd.write    = 1'b1;
                        cmd.res_code = STAT_OK;
                    end
                end
            end
            S_SUM:
            begin
                cmd.walk_en = 1'b1;
                cmd.mode    = WALK_SUM;
                if (stat.walk_done)
                begin
                    if (stat.total_zero)
                    begin
                        cmd.res_en   = 1'b1;
                        cmd.res_code = STAT_NONE;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.mul_init = 1'b1;
                        state_next   = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.walk_en = 1'b1;
                cmd.mode    = WALK_PICK;
                if (stat.hit)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_code = STAT_OK;
                    cmd.res_pick = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.walk_done)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_code = STAT_NONE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/wis_dp.sv
// ============================================================================
// wis_dp
// Datapath: entry memory, rank counts, id maps, walk, accumulators,
// bit-serial scale multiplier and result registers.
// ============================================================================
module wis_dp #(
    parameter int RANKS            = wis_pkg::RANKS_DEF,
    parameter int ENTRIES_PER_RANK = wis_pkg::ENTRIES_PER_RANK_DEF,
    parameter int WEIGHT_BITS      = wis_pkg::WEIGHT_BITS_DEF,
    parameter int RANDOM_BITS      = wis_pkg::RANDOM_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wis_pkg::wis_cmd_t            cmd,
    output wis_pkg::wis_stat_t           stat,
    input  logic [wis_pkg::FUNC_W-1:0]   func,
    input  logic [wis_pkg::RANK_IW-1:0]  rank,
    input  logic [wis_pkg::ID_W-1:0]     item_id,
    input  logic [wis_pkg::WEIGHT_IW-1:0] weight,
    input  logic [wis_pkg::FRAC_IW-1:0]  random_fraction,
    output logic                         done,
    output logic [wis_pkg::STATUS_W-1:0] status,
    output logic [wis_pkg::ID_W-1:0]     chosen_item
);
    import wis_pkg::*;

    localparam int SLOTS      = RANKS * ENTRIES_PER_RANK;
    localparam int ADDR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RANK_W     = (RANKS > 1) ? $clog2(RANKS) : 1;
    localparam int RANK_SLOTS = 2 ** RANK_W;
    localparam int CNT_W      = $clog2(ENTRIES_PER_RANK + 1);
    localparam int TOTAL_W    = WEIGHT_BITS + CNT_W;
    localparam int PROD_W     = TOTAL_W + RANDOM_BITS;
    localparam int MUL_CW     = $clog2(RANDOM_BITS + 1);

    // Request fields
    func_t                  func_reg;
    logic [RANK_IW-1:0]     rank_reg;
    logic [ID_W-1:0]        id_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [RANDOM_BITS-1:0] frac_reg;

    // Entry memory
    logic [ID_W-1:0]        ids_mem [0:SLOTS-1];
    logic [WEIGHT_BITS-1:0] wts_mem [0:SLOTS-1];
    logic [ID_W-1:0]        ids_q_reg;
    logic [WEIGHT_BITS-1:0] wts_q_reg;

    // Rank fill and id maps
    logic [CNT_W-1:0]   counts_reg [0:RANK_SLOTS-1];
    logic [NUM_IDS-1:0] present_reg;
    logic [NUM_IDS-1:0] excl_reg;

    // Walk and arithmetic
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       rd_k_reg;
    logic                   rd_valid_reg;
    logic                   hit_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     acc_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [RANDOM_BITS-1:0] frac_sh_reg;
    logic [MUL_CW-1:0]      mul_cnt_reg;
    logic [ID_W-1:0]        pick_id_reg;

    // Result
    logic                   done_reg;
    status_t                status_reg;
    logic [ID_W-1:0]        chosen_reg;

    logic [RANK_W-1:0]  rank_idx;
    logic               rank_ok;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               issue;
    logic               masked;
    logic [TOTAL_W-1:0] wts_ext;
    logic [TOTAL_W-1:0] acc_next;
    logic [TOTAL_W-1:0] pick_val;
    logic               mul_run;

    assign rank_idx  = RANK_W'(rank_reg);
    assign rank_ok   = (int'(rank_reg) < RANKS);
    assign base_addr = ADDR_W'(int'(rank_idx) * ENTRIES_PER_RANK);
    assign rd_addr   = base_addr + ADDR_W'(rd_k_reg);
    assign wr_addr   = base_addr + ADDR_W'(cnt_reg);
    assign issue     = cmd.walk_en && (rd_k_reg != cnt_reg);
    assign masked    = excl_reg[ids_q_reg];
    assign wts_ext   = TOTAL_W'(wts_q_reg);
    assign acc_next  = acc_reg + wts_ext;
    assign pick_val  = prod_reg[PROD_W-1:RANDOM_BITS];
    assign mul_run   = cmd.mul_step && (mul_cnt_reg != MUL_CW'(RANDOM_BITS));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func_t'(func);
            rank_reg   <= rank;
            id_reg     <= item_id;
            weight_reg <= WEIGHT_BITS'(weight);
            frac_reg   <= RANDOM_BITS'(random_fraction);
        end
    end

    // Entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            ids_mem[wr_addr] <= id_reg;
            wts_mem[wr_addr] <= weight_reg;
        end
        if (issue)
        begin
            ids_q_reg <= ids_mem[rd_addr];
            wts_q_reg <= wts_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RANK_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
            end
            present_reg <= '0;
            excl_reg    <= '0;
        end
        else
        begin
            if (cmd.write)
            begin
                counts_reg[rank_idx] <= cnt_reg + CNT_W'(1);
                present_reg[id_reg]  <= 1'b1;
            end
            if (cmd.clr)
            begin
                excl_reg <= '0;
            end
            else if (cmd.excl && present_reg[id_reg])
            begin
                excl_reg[id_reg] <= 1'b1;
            end
        end
    end

    // Walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_k_reg     <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else if (cmd.prep || cmd.mul_init)
        begin
            if (cmd.prep)
            begin
                cnt_reg <= rank_ok ? counts_reg[rank_idx] : '0;
            end
            rd_k_reg     <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (issue)
            begin
                rd_k_reg <= rd_k_reg + CNT_W'(1);
            end
            if (cmd.walk_en && rd_valid_reg && !hit_reg)
            begin
                case (cmd.mode)
                    WALK_DUP:  hit_reg <= (ids_q_reg == id_reg);
                    WALK_PICK: hit_reg <= !masked && (pick_val < acc_next);
                    default:   hit_reg <= 1'b0;
                endcase
            end
            if (mul_run)
            begin
                mul_cnt_reg <= mul_cnt_reg + MUL_CW'(1);
            end
        end
    end

    // Sums, scale multiply and pick capture
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            total_reg <= '0;
            acc_reg   <= '0;
        end
        else if (cmd.mul_init)
        begin
            prod_reg    <= '0;
            frac_sh_reg <= frac_reg;
            acc_reg     <= '0;
        end
        else
        begin
            if (cmd.walk_en && rd_valid_reg && !hit_reg && !masked)
            begin
                case (cmd.mode)
                    WALK_SUM:
                    begin
                        total_reg <= total_reg + wts_ext;
                    end
                    WALK_PICK:
                    begin
                        acc_reg <= acc_next;
                        if (pick_val < acc_next)
                        begin
                            pick_id_reg <= ids_q_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (mul_run)
            begin
                // MSB-first shift-add: frac * total
                prod_reg <= (prod_reg << 1)
                          + (frac_sh_reg[RANDOM_BITS-1] ? PROD_W'(total_reg) : '0);
                frac_sh_reg <= frac_sh_reg << 1;
            end
        end
    end

    // Result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            status_reg <= cmd.res_code;
            chosen_reg <= cmd.res_pick ? pick_id_reg : '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign chosen_item = chosen_reg;

    assign stat.func       = func_reg;
    assign stat.rank_ok    = rank_ok;
    assign stat.present    = present_reg[id_reg];
    assign stat.full       = (cnt_reg >= CNT_W'(ENTRIES_PER_RANK));
    assign stat.hit        = hit_reg;
    assign stat.walk_done  = (rd_k_reg == cnt_reg) && !rd_valid_reg;
    assign stat.total_zero = (total_reg == '0);
    assign stat.mul_done   = (mul_cnt_reg == MUL_CW'(RANDOM_BITS));

endmodule

>>> hw/rtl/weighted_item_selector_core.sv
// ============================================================================
// Weighted item selector core
// Run time of add and roll grows with the rank fill and is set by the entry-memory
// walks and the serial multiply; exclude and clear need no walk. One request at a
// time: busy drops with done, so the next start is taken at the edge ending the
// done cycle. The receiver cannot stall. Reset clears rank counts, id maps and
// control; entry memory is left unwritten.
// ============================================================================
module weighted_item_selector_core #(
    parameter int RANKS            = wis_pkg::RANKS_DEF,
    parameter int ENTRIES_PER_RANK = wis_pkg::ENTRIES_PER_RANK_DEF,
    parameter int WEIGHT_BITS      = wis_pkg::WEIGHT_BITS_DEF,
    parameter int RANDOM_BITS      = wis_pkg::RANDOM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [wis_pkg::FUNC_W-1:0]    func,
    input  logic [wis_pkg::RANK_IW-1:0]   rank,
    input  logic [wis_pkg::ID_W-1:0]      item_id,
    input  logic [wis_pkg::WEIGHT_IW-1:0] weight,
    input  logic [wis_pkg::FRAC_IW-1:0]   random_fraction,
    output logic                          done,
    output logic [wis_pkg::STATUS_W-1:0]  status,
    output logic [wis_pkg::ID_W-1:0]      chosen_item
);
    import wis_pkg::*;

    // Command/status between sequencer and datapath
    wis_cmd_t  cmd;
    wis_stat_t stat;

    // Sequencer: one request beat in, one result beat out.
    // Add walks the rank for a duplicate id, then appends if none is found and the rank is not full.
    // Roll walks the rank twice: first to total the unmasked weights,
    // then, after a bit-serial frac*total, to find the first running sum
    // above the scaled pick.
    wis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath: entry memory (RANKS*ENTRIES_PER_RANK slots, one read and
    // one write port), rank counts and the id presence/exclusion maps in
    // flops, walk counter, accumulators and result registers.
    wis_dp #(
        .RANKS            (RANKS),
        .ENTRIES_PER_RANK (ENTRIES_PER_RANK),
        .WEIGHT_BITS      (WEIGHT_BITS),
        .RANDOM_BITS      (RANDOM_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .func            (func),
        .rank            (rank),
        .item_id         (item_id),
        .weight          (weight),
        .random_fraction (random_fraction),
        .done            (done),
        .status          (status),
        .chosen_item     (chosen_item)
    );

`ifndef NO_ASSERTIONS
    // A result beat closes the request: busy just dropped
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without end of busy");

    // An accepted request keeps the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Result beats never come back to back
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in a row");

    // Failed requests report no item
    a_no_item_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |-> (chosen_item == '0))
        else $error("chosen_item set on failed request");
`endif

endmodule
